/* rtl/spd_pkg.sv */
// Shared constants and request/result types for the stroke phase detector.
package spd_pkg;

  localparam int RingDepth = 8;
  localparam int PtrW      = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int FillW     = $clog2(RingDepth + 1);
  localparam int PeriodW   = 32;
  localparam int SumW      = PeriodW + PtrW;
  localparam int TimeW     = 48;
  localparam int RateW     = 16;

  // 60 s * 1e6 us * 16 sub-units
  localparam longint unsigned SpmScale = 64'd960000000;
  localparam int NumW    = $clog2(SpmScale * RingDepth + 1);
  localparam int DivCntW = $clog2(NumW + 1);

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  typedef struct packed {
    logic signed [15:0] accel;
    logic [TimeW-1:0]   timestamp;
  } spd_in_t;

  typedef struct packed {
    logic               stroke_done;
    logic [1:0]         phase_now;
    logic signed [15:0] peak_accel;
    logic [31:0]        stroke_dur;
    logic [RateW-1:0]   rate_spm;
    logic               rate_valid;
    logic [31:0]        stroke_total;
  } spd_out_t;

endpackage

/* rtl/stroke_phase_detector_core.sv */
// Stroke phase detector: phase tracking, period ring memory and rate divider.
//
// Usage:
//   in_valid/in_stall/in_data carry one sample request (accel, timestamp).
//   out_valid/out_stall/out_data carry one result per sample.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the five setup registers;
//   cfg_ready is high outside reset, write only while the block is idle.
// Sequence of states:
//   A sample that records no period goes S_IDLE, S_EVAL, S_OUT; the next
//   sample is accepted once the block is back in S_IDLE.
//   A sample that records a period goes S_EVAL, S_READ, S_DIV, S_FIN, S_OUT:
//   the ring memory is read one entry a cycle to build the window's sum,
//   then a restoring divider retires one quotient bit a cycle (NumW = 33).
//   One sample is processed at a time; in_stall is high meanwhile.
// Reset (rst, synchronous): phase goes to recovery, counters and rate clear,
//   registers take their defaults. Ring entries are not cleared; only written
//   entries are read.
// Stall: a finished result waits in the output register while out_stall is
//   high; the next sample is taken meanwhile and held until the register frees.
module stroke_phase_detector_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  spd_pkg::spd_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output spd_pkg::spd_out_t           out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [spd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [spd_pkg::CfgDataW-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_READ, S_DIV, S_FIN, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_RECOVERY = 2'd0,
    PH_CATCH    = 2'd1,
    PH_PULL     = 2'd2,
    PH_RELEASE  = 2'd3
  } phase_t;

  typedef enum logic [spd_pkg::CfgIdxW-1:0] {
    CFG_CATCH    = 3'd0,
    CFG_RECOVERY = 3'd1,
    CFG_SMOOTH   = 3'd2,
    CFG_MIN_DUR  = 3'd3,
    CFG_MAX_DUR  = 3'd4
  } cfg_idx_t;

  localparam int SmoothReset = (spd_pkg::RingDepth < 4) ? spd_pkg::RingDepth : 4;

  state_t state;
  phase_t phase;

  // setup registers
  logic signed [15:0]           catch_thr;
  logic signed [15:0]           recovery_thr;
  logic [spd_pkg::FillW-1:0]    smooth_count;
  logic [31:0]                  min_duration;
  logic [31:0]                  max_duration;

  // stroke state
  logic [spd_pkg::TimeW-1:0]    start_time;
  logic                         start_seen;
  logic [spd_pkg::TimeW-1:0]    prior_start_time;
  logic                         prior_start_valid;
  logic signed [15:0]           peak;
  logic [spd_pkg::PtrW-1:0]     ring_ptr;
  logic [spd_pkg::FillW-1:0]    ring_fill;
  logic [spd_pkg::RateW-1:0]    last_rate;
  logic [31:0]                  last_duration;
  logic [31:0]                  stroke_cnt;
  logic                         done_flag;

  spd_pkg::spd_in_t             req;

  // ring memory and sum / divide datapath
  logic [spd_pkg::PeriodW-1:0]  ring_mem [spd_pkg::RingDepth];
  logic [spd_pkg::PeriodW-1:0]  rd_data;
  logic [spd_pkg::PtrW-1:0]     rd_addr;
  logic [spd_pkg::FillW-1:0]    rd_left;
  logic                         rd_live;
  logic [spd_pkg::FillW-1:0]    window;
  logic [spd_pkg::SumW-1:0]     sum;
  logic [spd_pkg::NumW-1:0]     num;
  logic [spd_pkg::SumW-1:0]     rem;
  logic [spd_pkg::DivCntW-1:0]  div_cnt;

  // evaluation of the held sample
  phase_t                       ev_phase;
  logic signed [15:0]           ev_peak;
  logic [spd_pkg::TimeW-1:0]    ev_start;
  logic                         ev_seen;
  logic [spd_pkg::TimeW-1:0]    ev_prior;
  logic                         ev_prior_valid;
  logic                         ev_done;
  logic                         ev_record;
  logic [spd_pkg::TimeW-1:0]    dur;
  logic [spd_pkg::TimeW-1:0]    diff;
  logic [spd_pkg::PeriodW-1:0]  period;
  logic [spd_pkg::FillW-1:0]    fill_new;
  logic [spd_pkg::FillW-1:0]    win_new;
  logic [spd_pkg::PtrW-1:0]     ptr_inc;
  logic [spd_pkg::PtrW-1:0]     addr_dec;
  logic                         ring_we;

  logic [spd_pkg::SumW:0]       trial;
  logic                         qbit;
  logic [3:0]                   smooth_wr;

  assign in_stall  = rst || (state != S_IDLE);
  assign cfg_ready = !rst;
  assign smooth_wr = cfg_data[3:0];

  always_comb begin
    ev_phase       = phase;
    ev_peak        = peak;
    ev_start       = start_time;
    ev_seen        = start_seen;
    ev_prior       = prior_start_time;
    ev_prior_valid = prior_start_valid;
    ev_done        = 1'b0;
    ev_record      = 1'b0;
    dur            = req.timestamp - start_time;
    unique case (phase)
      PH_RECOVERY: begin
        if (req.accel > catch_thr) begin
          ev_phase       = PH_CATCH;
          ev_prior       = start_time;
          ev_prior_valid = start_seen;
          ev_start       = req.timestamp;
          ev_seen        = 1'b1;
          ev_peak        = req.accel;
        end
      end
      PH_CATCH: begin
        if (req.accel > peak) begin
          ev_peak  = req.accel;
          ev_phase = PH_PULL;
        end else if (req.accel < recovery_thr) begin
          ev_phase = PH_RECOVERY;
        end
      end
      PH_PULL: begin
        if (req.accel > peak) ev_peak = req.accel;
        if (req.accel < recovery_thr) ev_phase = PH_RELEASE;
      end
      PH_RELEASE: begin
        if (req.accel < recovery_thr) begin
          ev_phase = PH_RECOVERY;
          // backwards time or out-of-window duration is not a stroke
          if (req.timestamp >= start_time &&
              dur >= {16'b0, min_duration} && dur <= {16'b0, max_duration}) begin
            ev_done   = 1'b1;
            ev_record = prior_start_valid;
          end
        end else if (req.accel > catch_thr) begin
          ev_phase = PH_PULL;
        end
      end
      default: ev_phase = phase;
    endcase
  end

  always_comb begin
    diff = start_time - prior_start_time;
    if (start_time < prior_start_time) period = '0;
    else if (diff[spd_pkg::TimeW-1:spd_pkg::PeriodW] != '0) period = '1;
    else period = diff[spd_pkg::PeriodW-1:0];

    fill_new = (32'(ring_fill) < spd_pkg::RingDepth) ? ring_fill + 1'b1 : ring_fill;
    win_new  = (smooth_count < fill_new) ? smooth_count : fill_new;
    ptr_inc  = (ring_ptr == spd_pkg::PtrW'(spd_pkg::RingDepth - 1)) ? '0
                                                                      : ring_ptr + 1'b1;
    addr_dec = (rd_addr == '0) ? spd_pkg::PtrW'(spd_pkg::RingDepth - 1) : rd_addr - 1'b1;
    ring_we  = (state == S_EVAL) && ev_record;

    trial = {rem, num[spd_pkg::NumW-1]};
    qbit  = (trial >= {1'b0, sum});
  end

  // period ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_ptr] <= period;
    rd_data <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      phase             <= PH_RECOVERY;
      catch_thr         <= 16'sd6144;
      recovery_thr      <= 16'sd2048;
      smooth_count      <= spd_pkg::FillW'(SmoothReset);
      min_duration      <= 32'd200000;
      max_duration      <= 32'd3000000;
      start_time        <= '0;
      start_seen        <= 1'b0;
      prior_start_time  <= '0;
      prior_start_valid <= 1'b0;
      peak              <= '0;
      ring_ptr          <= '0;
      ring_fill         <= '0;
      last_rate         <= '0;
      last_duration     <= '0;
      stroke_cnt        <= '0;
      done_flag         <= 1'b0;
      rd_live           <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      // S_OUT keeps or reloads the output register itself
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;

      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_CATCH:    catch_thr    <= cfg_data[15:0];
          CFG_RECOVERY: recovery_thr <= cfg_data[15:0];
          CFG_SMOOTH: begin
            if (smooth_wr == '0) smooth_count <= spd_pkg::FillW'(1);
            else if (32'(smooth_wr) > spd_pkg::RingDepth)
              smooth_count <= spd_pkg::FillW'(spd_pkg::RingDepth);
            else smooth_count <= spd_pkg::FillW'(smooth_wr);
          end
          CFG_MIN_DUR:  min_duration <= cfg_data;
          CFG_MAX_DUR:  max_duration <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          phase             <= ev_phase;
          peak              <= ev_peak;
          start_time        <= ev_start;
          start_seen        <= ev_seen;
          prior_start_time  <= ev_prior;
          prior_start_valid <= ev_prior_valid;
          done_flag         <= ev_done;
          if (ev_done) begin
            last_duration <= dur[31:0];
            stroke_cnt    <= stroke_cnt + 1'b1;
          end
          if (ev_record) begin
            ring_ptr  <= ptr_inc;
            ring_fill <= fill_new;
            window    <= win_new;
            rd_addr   <= ring_ptr;  // newest entry first, written this cycle
            rd_left   <= win_new;
            rd_live   <= 1'b0;
            sum       <= '0;
            state     <= S_READ;
          end else begin
            state <= S_OUT;
          end
        end
        S_READ: begin
          if (rd_live) sum <= sum + spd_pkg::SumW'(rd_data);
          if (rd_left != '0) begin
            rd_addr <= addr_dec;
            rd_left <= rd_left - 1'b1;
            rd_live <= 1'b1;
          end else begin
            rd_live <= 1'b0;
            if (!rd_live) begin
              num     <= spd_pkg::NumW'(spd_pkg::SpmScale * 64'(window));
              rem     <= '0;
              div_cnt <= spd_pkg::DivCntW'(spd_pkg::NumW);
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem     <= qbit ? spd_pkg::SumW'(trial - {1'b0, sum})
                          : spd_pkg::SumW'(trial);
          num     <= {num[spd_pkg::NumW-2:0], qbit};
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == spd_pkg::DivCntW'(1)) state <= S_FIN;
        end
        S_FIN: begin
          // zero sum and oversize quotient both saturate
          if (sum == '0 || num > spd_pkg::NumW'(16'hFFFF)) last_rate <= '1;
          else last_rate <= num[spd_pkg::RateW-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_data.stroke_done  <= done_flag;
            out_data.phase_now    <= phase;
            out_data.peak_accel   <= peak;
            out_data.stroke_dur   <= last_duration;
            out_data.rate_spm     <= last_rate;
            out_data.rate_valid   <= (ring_fill != '0);
            out_data.stroke_total <= stroke_cnt;
            out_valid             <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a request is in progress");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(ring_fill) <= spd_pkg::RingDepth)
    else $error("ring fill beyond depth");

  a_rate_needs_period: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.rate_valid) |-> (out_data.rate_spm == '0))
    else $error("rate reported before any period was recorded");

  a_done_in_recovery: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.stroke_done) |-> (out_data.phase_now == PH_RECOVERY))
    else $error("stroke confirmed outside recovery");

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (window != '0 && window <= ring_fill))
    else $error("averaging window out of range");

endmodule
